// ===== hw/rtl/lrct_pkg.sv =====
// ----------------------------------------------------------------------------
// lrct_pkg - shared types and constants for the render cache tag unit
// Field widths, register map, request codes and the packed tag entry.
// ----------------------------------------------------------------------------
package lrct_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int PAGE_W    = 15;
  localparam int PIDX_W    = 16;
  localparam int DIM_W     = 13;
  localparam int SCALE_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int LIMIT_W   = 7;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DIV_STEPS = PIDX_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [LIMIT_W-1:0] CACHE_LIMIT_RST = LIMIT_W'(32);
  localparam logic [PAGE_W-1:0]  PAGE_COUNT_RST  = PAGE_W'(1);

  // register index, taken from the word address bit of paddr
  typedef enum logic {
    REG_CACHE_LIMIT = 1'b0,
    REG_PAGE_COUNT  = 1'b1
  } reg_sel_t;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] scale;
  } tag_t;

endpackage

// ===== hw/rtl/lru_render_cache_tags_unit.sv =====
// ----------------------------------------------------------------------------
// lru_render_cache_tags_unit - fully associative LRU tag store
// Looks up a (page, width, height, scale) key, answers hit or miss with a
// slot, replaces the least recently used entry when the cache is full.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request (lookup or flush), out_* channel carries
//   one result per request; both use valid/stall, a transfer happens when
//   valid is high and stall is low. The user must write cache_limit and
//   page_count through the APB port only while the unit is idle; the unit
//   itself does not enforce this. A lookup runs through a 16-step restoring
//   remainder unit to wrap the page, a fix-up step for negative pages, one
//   pass over the tag and age memories to compare keys and find the oldest
//   and first free slot, a decide state, a second pass that rewrites the
//   ages and the output state. A new request is not taken until the last
//   one has left the output state. A flush clears all entries and goes
//   straight to the output state.
//   in_stall is high while a request is being worked on. A finished result
//   sits in the output register; the next request is taken while it waits,
//   and only the final write of a later result waits for the receiver.
//   Reset clears all valid bits and the entry count, loads cache_limit 32 and
//   page_count 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_render_cache_tags_unit #(
  parameter int MAX_ENTRIES = lrct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic signed [lrct_pkg::PIDX_W-1:0] in_page_index,
  input  logic [lrct_pkg::DIM_W-1:0]         in_render_width,
  input  logic [lrct_pkg::DIM_W-1:0]         in_render_height,
  input  logic [lrct_pkg::SCALE_W-1:0]       in_render_scale,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [lrct_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_evicted,
  output logic [lrct_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [lrct_pkg::PAGE_W-1:0]        out_wrapped_page,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lrct_pkg::ADDR_W-1:0]        paddr,
  input  logic [lrct_pkg::DATA_W-1:0]        pwdata,
  output logic [lrct_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AGE_W = IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_SCAN,
    ST_DECIDE,
    ST_PROM,
    ST_OUT
  } state_t;

  state_t state_r;

  logic [lrct_pkg::LIMIT_W-1:0] cache_limit_r;
  logic [lrct_pkg::PAGE_W-1:0]  page_count_r;

  logic [MAX_ENTRIES-1:0] vld_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       idx_r;
  logic [lrct_pkg::STEP_W-1:0] step_r;

  // request payload
  logic                         neg_r;
  logic [lrct_pkg::PAGE_W-1:0]  n_r;
  logic [lrct_pkg::PIDX_W-1:0]  dvd_r;
  logic [lrct_pkg::PAGE_W-1:0]  rem_r;
  logic [lrct_pkg::PAGE_W-1:0]  pg_r;
  logic [lrct_pkg::DIM_W-1:0]   wid_r;
  logic [lrct_pkg::DIM_W-1:0]   hgt_r;
  logic [lrct_pkg::SCALE_W-1:0] scl_r;

  // scan results
  logic                        rd_pend_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic                        found_r;
  logic [IDX_W-1:0]            hit_sel_r;
  logic [AGE_W-1:0]            hit_age_r;
  logic                        free_found_r;
  logic [IDX_W-1:0]            free_sel_r;
  logic [IDX_W-1:0]            ev_sel_r;
  logic [AGE_W-1:0]            oldest_r;
  logic [lrct_pkg::PAGE_W-1:0] ev_page_r;

  // promote pass
  logic [IDX_W-1:0] sel_r;
  logic [AGE_W-1:0] lim_age_r;
  logic             lim_inf_r;

  // finished result
  logic                        res_hit_r;
  logic                        res_evicted_r;
  logic [lrct_pkg::PAGE_W-1:0] res_ev_page_r;
  logic [lrct_pkg::PAGE_W-1:0] res_wrapped_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lrct_pkg::SLOT_W-1:0] out_slot_r;
  logic                        out_evicted_r;
  logic [lrct_pkg::PAGE_W-1:0] out_ev_page_r;
  logic [lrct_pkg::PAGE_W-1:0] out_wrapped_r;

  // memories
  lrct_pkg::tag_t   tag_mem [MAX_ENTRIES];
  logic [AGE_W-1:0] age_mem [MAX_ENTRIES];
  lrct_pkg::tag_t   tag_rd_r;
  logic [AGE_W-1:0] age_rd_r;

  logic                         in_xfer;
  logic                         cfg_wr;
  logic                         rd_issue;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_vld_bit;
  logic                         key_match;
  logic [lrct_pkg::PIDX_W-1:0]  div_a;
  logic [lrct_pkg::PIDX_W-1:0]  sub_a;
  logic [lrct_pkg::PIDX_W-1:0]  sub_b;
  logic [lrct_pkg::PIDX_W:0]    sub_diff;
  logic [lrct_pkg::PIDX_W-1:0]  pidx_u;
  logic [lrct_pkg::PIDX_W-1:0]  mag;
  logic [CNT_W-1:0]             lim_eff;
  logic                         do_evict;
  logic                         age_we;
  logic [AGE_W-1:0]             age_wd;
  logic                         tag_we;
  logic [IDX_W-1:0]             tag_wa;
  lrct_pkg::tag_t               tag_wd;
  logic                         out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_ev_page_r;
  assign out_wrapped_page = out_wrapped_r;

  always_comb begin
    case (lrct_pkg::reg_sel_t'(paddr[2]))
      lrct_pkg::REG_CACHE_LIMIT: prdata = lrct_pkg::DATA_W'(cache_limit_r);
      lrct_pkg::REG_PAGE_COUNT:  prdata = lrct_pkg::DATA_W'(page_count_r);
      default:                   prdata = '0;
    endcase
  end

  // page magnitude for the remainder unit; negative values wrap from the top
  assign pidx_u = in_page_index;
  assign mag    = pidx_u[lrct_pkg::PIDX_W-1] ?
                  lrct_pkg::PIDX_W'(17'h10000 - {1'b0, pidx_u}) : pidx_u;

  // shared subtractor: remainder steps, then the negative fix-up n - rem
  assign div_a = {rem_r, dvd_r[lrct_pkg::PIDX_W-1]};
  always_comb begin
    if (state_r == ST_FIX) begin
      sub_a = {1'b0, n_r};
      sub_b = {1'b0, rem_r};
    end else begin
      sub_a = div_a;
      sub_b = {1'b0, n_r};
    end
  end
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};

  assign rd_issue   = ((state_r == ST_SCAN) || (state_r == ST_PROM)) &&
                      (idx_r < CNT_W'(MAX_ENTRIES));
  assign rd_addr    = rd_issue ? idx_r[IDX_W-1:0] : '0;
  assign rd_vld_bit = vld_r[rd_idx_r];
  assign key_match  = (tag_rd_r.page == pg_r) && (tag_rd_r.width == wid_r) &&
                      (tag_rd_r.height == hgt_r) && (tag_rd_r.scale == scl_r);

  // limit of zero acts as one, above the entry count saturates
  always_comb begin
    if (cache_limit_r == '0) begin
      lim_eff = CNT_W'(1);
    end else if (32'(cache_limit_r) > MAX_ENTRIES) begin
      lim_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      lim_eff = CNT_W'(cache_limit_r);
    end
  end
  assign do_evict = (count_r >= lim_eff) && (count_r != '0);

  // age update: chosen slot becomes 0, younger valid entries age by one
  assign age_we = (state_r == ST_PROM) && rd_pend_r &&
                  ((rd_idx_r == sel_r) ||
                   (rd_vld_bit && (lim_inf_r || (age_rd_r < lim_age_r))));
  assign age_wd = (rd_idx_r == sel_r) ? '0 : age_rd_r + AGE_W'(1);

  assign tag_we = (state_r == ST_DECIDE) && !found_r;
  assign tag_wa = do_evict ? ev_sel_r : free_sel_r;
  assign tag_wd = '{page: pg_r, width: wid_r, height: hgt_r, scale: scl_r};

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[rd_addr];
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
  end

  always_ff @(posedge clk) begin
    age_rd_r <= age_mem[rd_addr];
    if (age_we) begin
      age_mem[rd_idx_r] <= age_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cache_limit_r <= lrct_pkg::CACHE_LIMIT_RST;
      page_count_r  <= lrct_pkg::PAGE_COUNT_RST;
      vld_r         <= '0;
      count_r       <= '0;
      idx_r         <= '0;
      step_r        <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_pend_r <= rd_issue;
      rd_idx_r  <= rd_addr;

      if (cfg_wr) begin
        case (lrct_pkg::reg_sel_t'(paddr[2]))
          lrct_pkg::REG_CACHE_LIMIT: cache_limit_r <= pwdata[lrct_pkg::LIMIT_W-1:0];
          lrct_pkg::REG_PAGE_COUNT:  page_count_r  <= pwdata[lrct_pkg::PAGE_W-1:0];
          default: ;
        endcase
      end

      // a new result loads, a stalled one is held, a taken one drops
      out_valid_r <= out_load || (out_valid_r && out_stall);

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_req_type == lrct_pkg::REQ_FLUSH) begin
              vld_r         <= '0;
              count_r       <= '0;
              res_hit_r     <= 1'b0;
              res_evicted_r <= 1'b0;
              res_ev_page_r <= '0;
              res_wrapped_r <= '0;
              sel_r         <= '0;
              state_r       <= ST_OUT;
            end else begin
              neg_r   <= pidx_u[lrct_pkg::PIDX_W-1];
              n_r     <= (page_count_r == '0) ? lrct_pkg::PAGE_W'(1) : page_count_r;
              dvd_r   <= mag;
              rem_r   <= '0;
              wid_r   <= in_render_width;
              hgt_r   <= in_render_height;
              scl_r   <= in_render_scale;
              step_r  <= '0;
              state_r <= ST_DIV;
            end
          end
        end

        // restoring remainder, one dividend bit a cycle
        ST_DIV: begin
          if (!sub_diff[lrct_pkg::PIDX_W]) begin
            rem_r <= sub_diff[lrct_pkg::PAGE_W-1:0];
          end else begin
            rem_r <= div_a[lrct_pkg::PAGE_W-1:0];
          end
          dvd_r  <= {dvd_r[lrct_pkg::PIDX_W-2:0], 1'b0};
          step_r <= step_r + lrct_pkg::STEP_W'(1);
          if (step_r == lrct_pkg::STEP_W'(lrct_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_FIX;
          end
        end

        ST_FIX: begin
          if (neg_r && (rem_r != '0)) begin
            pg_r <= sub_diff[lrct_pkg::PAGE_W-1:0];
          end else begin
            pg_r <= rem_r;
          end
          found_r      <= 1'b0;
          free_found_r <= 1'b0;
          free_sel_r   <= '0;
          hit_sel_r    <= '0;
          hit_age_r    <= '0;
          ev_sel_r     <= '0;
          oldest_r     <= '0;
          ev_page_r    <= '0;
          idx_r        <= '0;
          state_r      <= ST_SCAN;
        end

        ST_SCAN: begin
          if (rd_pend_r) begin
            if (rd_vld_bit) begin
              if (!found_r && key_match) begin
                found_r   <= 1'b1;
                hit_sel_r <= rd_idx_r;
                hit_age_r <= age_rd_r;
              end
              if (age_rd_r >= oldest_r) begin
                oldest_r  <= age_rd_r;
                ev_sel_r  <= rd_idx_r;
                ev_page_r <= tag_rd_r.page;
              end
            end else if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_sel_r   <= rd_idx_r;
            end
          end
          if (idx_r == CNT_W'(MAX_ENTRIES)) begin
            state_r <= ST_DECIDE;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end

        ST_DECIDE: begin
          res_wrapped_r <= pg_r;
          res_hit_r     <= found_r;
          res_evicted_r <= 1'b0;
          res_ev_page_r <= '0;
          lim_inf_r     <= 1'b0;
          if (found_r) begin
            sel_r     <= hit_sel_r;
            lim_age_r <= hit_age_r;
          end else if (do_evict) begin
            sel_r         <= ev_sel_r;
            lim_age_r     <= oldest_r;
            res_evicted_r <= 1'b1;
            res_ev_page_r <= ev_page_r;
          end else begin
            sel_r             <= free_sel_r;
            lim_age_r         <= '0;
            lim_inf_r         <= 1'b1;
            vld_r[free_sel_r] <= 1'b1;
            count_r           <= count_r + CNT_W'(1);
          end
          idx_r   <= '0;
          state_r <= ST_PROM;
        end

        ST_PROM: begin
          if (idx_r == CNT_W'(MAX_ENTRIES)) begin
            state_r <= ST_OUT;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end

        ST_OUT: begin
          if (out_load) begin
            out_hit_r     <= res_hit_r;
            out_slot_r    <= lrct_pkg::SLOT_W'(sel_r);
            out_evicted_r <= res_evicted_r;
            out_ev_page_r <= res_ev_page_r;
            out_wrapped_r <= res_wrapped_r;
            state_r       <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // entry count tracks the number of valid slots
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(vld_r)) == 32'(count_r))
    else $error("entry count differs from number of valid slots");

  // a flush empties the cache at once
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_req_type == lrct_pkg::REQ_FLUSH)) |=> (count_r == '0))
    else $error("flush did not clear the cache");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit and eviction reported together");

  // a new result only comes from the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result transfer raised outside the output state");

  // wrapped page lies below the page count
  a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_wrapped_r < page_count_r) || (out_wrapped_r == '0)))
    else $error("wrapped page out of range");
`endif

endmodule
